>>> sv/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and helper functions of the wheel odometry unit.
// ----------------------------------------------------------------------------
package odo_pkg;

    // Datapath widths
    localparam int MUL_W  = 36;   // signed multiplier operand
    localparam int PROD_W = 72;   // multiplier product
    localparam int DIV_W  = 55;   // divider dividend / quotient magnitude
    localparam int DVS_W  = 48;   // divider divisor
    localparam int DIV_STEPS = 55;
    localparam int CNT_W  = 6;

    // Angle to phase scale: 2^32 / 2pi
    localparam logic [MUL_W-1:0] TURN_K    = 36'd683565276;
    // Quarter-wave sine polynomial coefficients, Q1.30
    localparam logic [30:0]      SIN_A     = 31'd1686629713;
    localparam logic [30:0]      SIN_B     = 31'd693598671;
    localparam logic [MUL_W-1:0] SIN_C     = 36'd80710782;
    localparam logic [31:0]      ONE_Q30   = 32'd1073741824;
    localparam logic [31:0]      QUARTER   = 32'h4000_0000;
    // Microseconds per second
    localparam logic [MUL_W-1:0] VEL_SCALE = 36'd1000000;

    // Register map
    localparam logic REG_RADIUS     = 1'b0;
    localparam logic REG_SEPARATION = 1'b1;

    // Trig result slots
    localparam logic [1:0] TRIG_COS  = 2'd0;
    localparam logic [1:0] TRIG_SIN  = 2'd1;
    localparam logic [1:0] TRIG_HSIN = 2'd2;
    localparam logic [1:0] TRIG_HCOS = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_SUM,
        OP_MUL_DIF,
        OP_DIV_TH,
        OP_TH_FIN,
        OP_HEAD,
        OP_MUL_PH,
        OP_PH,
        OP_SIN_PREP,
        OP_SIN_SQ,
        OP_SIN_C,
        OP_SIN_B,
        OP_SIN_BM,
        OP_SIN_A,
        OP_SIN_AM,
        OP_SIN_FIN,
        OP_MUL_X,
        OP_MUL_Y,
        OP_ACC_Y,
        OP_DIV_LIN,
        OP_LIN_FIN,
        OP_MUL_ANG,
        OP_DIV_ANG,
        OP_ANG_FIN,
        OP_ZERO_VEL,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_SUM,
        S_MUL_DIF,
        S_DIV_TH,
        S_WAIT_TH,
        S_HEAD,
        S_MUL_PH,
        S_PH,
        S_SIN_PREP,
        S_SIN_SQ,
        S_SIN_C,
        S_SIN_B,
        S_SIN_BM,
        S_SIN_A,
        S_SIN_AM,
        S_SIN_FIN,
        S_MUL_X,
        S_MUL_Y,
        S_ACC_Y,
        S_DIV_LIN,
        S_WAIT_LIN,
        S_MUL_ANG,
        S_DIV_ANG,
        S_WAIT_ANG,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [1:0] sidx;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic dt_zero;
        logic out_free;
    } t_status;

    // Saturate to 32 bit signed
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > 72'sd2147483647) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -72'sd2147483648) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // Clamp a step to +-2^32
    function automatic logic signed [33:0] clamp_step(input logic signed [PROD_W-1:0] v);
        if (v > 72'sd4294967296) begin
            clamp_step = 34'sd4294967296;
        end else if (v < -72'sd4294967296) begin
            clamp_step = -34'sd4294967296;
        end else begin
            clamp_step = v[33:0];
        end
    endfunction

endpackage

>>> sv/odo_div.sv
// ----------------------------------------------------------------------------
// odo_div
// Restoring divider, one quotient bit per cycle, unsigned magnitude.
// ----------------------------------------------------------------------------
module odo_div import odo_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_mag,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] diff;

    // Shift in the next dividend bit and trial-subtract
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b0, r_dvs};

    // Control flags
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_cnt == CNT_W'(1))) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Iterate one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_mag;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_quo <= {r_quo[DIV_W-2:0], ~diff[DVS_W+1]};
            if (!diff[DVS_W+1]) begin
                r_rem <= diff[DVS_W-1:0];
            end else begin
                r_rem <= rem_sh[DVS_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> sv/odo_dp.sv
// ----------------------------------------------------------------------------
// odo_dp
// Odometry datapath: state, shared multiplier, divider and result word.
// ----------------------------------------------------------------------------
module odo_dp import odo_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic        [19:0] i_wheel_radius,
    input  logic        [19:0] i_wheel_separation,
    input  logic signed [31:0] i_left_position,
    input  logic signed [31:0] i_right_position,
    input  logic signed [15:0] i_left_noise,
    input  logic signed [15:0] i_right_noise,
    input  logic        [47:0] i_time_stamp,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_heading,
    output logic signed [31:0] o_linear_velocity,
    output logic signed [31:0] o_angular_velocity,
    output logic signed [15:0] o_quat_z,
    output logic signed [15:0] o_quat_w,
    output logic               o_dt_zero
);

    // Architectural state
    logic signed [31:0] r_prev_left, r_prev_right;
    logic        [47:0] r_prev_time;
    logic signed [31:0] r_acc_x, r_acc_y, r_acc_h;

    // Work registers
    logic signed [33:0]       r_dl, r_dr;
    logic        [47:0]       r_dt;
    logic signed [33:0]       r_ds, r_dth;
    logic        [31:0]       r_ph, r_hph;
    logic        [1:0]        r_q;
    logic        [30:0]       r_f, r_x2, r_t;
    logic signed [31:0]       r_trig [4];
    logic signed [31:0]       r_lin, r_ang;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_out_valid;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic                     mul_en;
    logic signed [34:0]       sum_lr, dif_lr;
    logic signed [PROD_W-1:0] prod_abs;
    logic                     div_start, div_done;
    logic        [DVS_W-1:0]  div_dvs;
    logic        [DIV_W-1:0]  div_quo;
    logic signed [PROD_W-1:0] quo_signed;
    logic                     r_div_neg;
    logic        [31:0]       sin_p;
    logic        [31:0]       sin_t;
    logic signed [31:0]       sin_v;
    logic signed [31:0]       quat_z_sh, quat_w_sh;
    logic signed [PROD_W-1:0] step_full;

    assign sum_lr   = {r_dr[33], r_dr} + {r_dl[33], r_dl};
    assign dif_lr   = {r_dr[33], r_dr} - {r_dl[33], r_dl};
    assign prod_abs = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign step_full = r_prod >>> (FRAC_BITS + 1);
    assign quo_signed = r_div_neg ? -{{(PROD_W-DIV_W){1'b0}}, div_quo}
                                  :  {{(PROD_W-DIV_W){1'b0}}, div_quo};

    // Select multiplier operands
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (i_cmd.op)
            OP_MUL_SUM: begin
                mul_a = {16'b0, i_wheel_radius};
                mul_b = {sum_lr[34], sum_lr};
            end
            OP_MUL_DIF: begin
                mul_a = {16'b0, i_wheel_radius};
                mul_b = {dif_lr[34], dif_lr};
            end
            OP_MUL_PH: begin
                mul_a = {{4{r_acc_h[31]}}, r_acc_h};
                mul_b = TURN_K;
            end
            OP_SIN_SQ: begin
                mul_a = {5'b0, r_f};
                mul_b = {5'b0, r_f};
            end
            OP_SIN_C: begin
                mul_a = {5'b0, r_prod[60:30]};
                mul_b = SIN_C;
            end
            OP_SIN_BM: begin
                mul_a = {5'b0, r_x2};
                mul_b = {5'b0, r_t};
            end
            OP_SIN_AM: begin
                mul_a = {5'b0, r_f};
                mul_b = {5'b0, r_t};
            end
            OP_MUL_X: begin
                mul_a = {{2{r_ds[33]}}, r_ds};
                mul_b = {{4{r_trig[TRIG_COS][31]}}, r_trig[TRIG_COS]};
            end
            OP_MUL_Y: begin
                mul_a = {{2{r_ds[33]}}, r_ds};
                mul_b = {{4{r_trig[TRIG_SIN][31]}}, r_trig[TRIG_SIN]};
            end
            OP_ACC_Y: begin
                mul_a = {{2{r_ds[33]}}, r_ds};
                mul_b = VEL_SCALE;
            end
            OP_MUL_ANG: begin
                mul_a = {{2{r_dth[33]}}, r_dth};
                mul_b = VEL_SCALE;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Register the product
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // Start the divider on heading-change, linear and angular divides
    always_comb begin
        div_start = 1'b0;
        div_dvs   = r_dt;
        case (i_cmd.op)
            OP_DIV_TH: begin
                div_start = 1'b1;
                div_dvs   = (i_wheel_separation == 20'd0) ? DVS_W'(1)
                                                          : DVS_W'(i_wheel_separation);
            end
            OP_DIV_LIN, OP_DIV_ANG: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_div_neg <= r_prod[PROD_W-1];
        end
    end

    odo_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_mag     (prod_abs[DIV_W-1:0]),
        .i_divisor (div_dvs),
        .o_done    (div_done),
        .o_quo     (div_quo)
    );

    // Pick the phase for this sine pass
    always_comb begin
        case (i_cmd.sidx)
            TRIG_COS: sin_p = r_ph + QUARTER;
            TRIG_SIN: sin_p = r_ph;
            TRIG_HSIN: sin_p = r_hph;
            default:  sin_p = r_hph + QUARTER;
        endcase
    end

    // Clamp the polynomial to one and apply the quadrant sign
    assign sin_t = (r_prod[61:30] > ONE_Q30) ? ONE_Q30 : r_prod[61:30];
    assign sin_v = r_q[1] ? -$signed(sin_t) : $signed(sin_t);

    // Update architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_prev_time  <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_acc_h      <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_prev_left  <= i_left_position;
                    r_prev_right <= i_right_position;
                    r_prev_time  <= i_time_stamp;
                end
                OP_HEAD: begin
                    r_acc_h <= sat32(PROD_W'(r_acc_h) + PROD_W'(r_dth));
                end
                OP_MUL_Y: begin
                    r_acc_x <= sat32(PROD_W'(r_acc_x) + (r_prod >>> 30));
                end
                OP_ACC_Y: begin
                    r_acc_y <= sat32(PROD_W'(r_acc_y) + (r_prod >>> 30));
                end
                default: begin
                    r_acc_h <= r_acc_h;
                end
            endcase
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_dl <= 34'(i_left_position) + 34'(i_left_noise) - 34'(r_prev_left);
                r_dr <= 34'(i_right_position) + 34'(i_right_noise) - 34'(r_prev_right);
                r_dt <= i_time_stamp - r_prev_time;
            end
            OP_MUL_DIF: begin
                r_ds <= clamp_step(step_full);
            end
            OP_TH_FIN: begin
                r_dth <= clamp_step(quo_signed);
            end
            OP_PH: begin
                r_ph  <= r_prod[FRAC_BITS+31:FRAC_BITS];
                r_hph <= r_prod[FRAC_BITS+32:FRAC_BITS+1];
            end
            OP_SIN_PREP: begin
                r_q <= sin_p[31:30];
                r_f <= sin_p[30] ? (31'd1073741824 - {1'b0, sin_p[29:0]})
                                 : {1'b0, sin_p[29:0]};
            end
            OP_SIN_C: begin
                r_x2 <= r_prod[60:30];
            end
            OP_SIN_B: begin
                r_t <= SIN_B - r_prod[60:30];
            end
            OP_SIN_A: begin
                r_t <= SIN_A - r_prod[60:30];
            end
            OP_SIN_FIN: begin
                r_trig[i_cmd.sidx] <= sin_v;
            end
            OP_LIN_FIN: begin
                r_lin <= sat32(quo_signed);
            end
            OP_ANG_FIN: begin
                r_ang <= sat32(quo_signed);
            end
            OP_ZERO_VEL: begin
                r_lin <= '0;
                r_ang <= '0;
            end
            default: begin
                r_dt <= r_dt;
            end
        endcase
    end

    // Quaternion parts, Q1.15
    assign quat_z_sh = r_trig[TRIG_HSIN] >>> 15;
    assign quat_w_sh = r_trig[TRIG_HCOS] >>> 15;

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            o_pos_x            <= r_acc_x;
            o_pos_y            <= r_acc_y;
            o_heading          <= r_acc_h;
            o_linear_velocity  <= r_lin;
            o_angular_velocity <= r_ang;
            o_quat_z <= (quat_z_sh > 32'sd32767) ? 16'sh7FFF : quat_z_sh[15:0];
            o_quat_w <= (quat_w_sh > 32'sd32767) ? 16'sh7FFF : quat_w_sh[15:0];
            o_dt_zero <= (r_dt == 48'd0);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.div_done = div_done;
    assign o_status.dt_zero  = (r_dt == 48'd0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

>>> sv/odo_ctrl.sv
// ----------------------------------------------------------------------------
// odo_ctrl
// Sequencer: steps the datapath through one odometry update per word.
// ----------------------------------------------------------------------------
module odo_ctrl import odo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_sidx, n_sidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sidx  <= '0;
        end else begin
            r_state <= n_state;
            r_sidx  <= n_sidx;
        end
    end

    // Next state and datapath command
    always_comb begin
        n_state    = r_state;
        n_sidx     = r_sidx;
        o_cmd.op   = OP_NOP;
        o_cmd.sidx = r_sidx;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_MUL_SUM;
                end
            end
            S_MUL_SUM: begin
                o_cmd.op = OP_MUL_SUM;
                n_state  = S_MUL_DIF;
            end
            S_MUL_DIF: begin
                o_cmd.op = OP_MUL_DIF;
                n_state  = S_DIV_TH;
            end
            S_DIV_TH: begin
                o_cmd.op = OP_DIV_TH;
                n_state  = S_WAIT_TH;
            end
            S_WAIT_TH: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_TH_FIN;
                    n_state  = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.op = OP_HEAD;
                n_state  = S_MUL_PH;
            end
            S_MUL_PH: begin
                o_cmd.op = OP_MUL_PH;
                n_state  = S_PH;
            end
            S_PH: begin
                o_cmd.op = OP_PH;
                n_sidx   = '0;
                n_state  = S_SIN_PREP;
            end
            S_SIN_PREP: begin
                o_cmd.op = OP_SIN_PREP;
                n_state  = S_SIN_SQ;
            end
            S_SIN_SQ: begin
                o_cmd.op = OP_SIN_SQ;
                n_state  = S_SIN_C;
            end
            S_SIN_C: begin
                o_cmd.op = OP_SIN_C;
                n_state  = S_SIN_B;
            end
            S_SIN_B: begin
                o_cmd.op = OP_SIN_B;
                n_state  = S_SIN_BM;
            end
            S_SIN_BM: begin
                o_cmd.op = OP_SIN_BM;
                n_state  = S_SIN_A;
            end
            S_SIN_A: begin
                o_cmd.op = OP_SIN_A;
                n_state  = S_SIN_AM;
            end
            S_SIN_AM: begin
                o_cmd.op = OP_SIN_AM;
                n_state  = S_SIN_FIN;
            end
            S_SIN_FIN: begin
                o_cmd.op = OP_SIN_FIN;
                n_sidx   = r_sidx + 2'd1;
                n_state  = (r_sidx == TRIG_HCOS) ? S_MUL_X : S_SIN_PREP;
            end
            S_MUL_X: begin
                o_cmd.op = OP_MUL_X;
                n_state  = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.op = OP_MUL_Y;
                n_state  = S_ACC_Y;
            end
            S_ACC_Y: begin
                o_cmd.op = OP_ACC_Y;
                n_state  = S_DIV_LIN;
            end
            S_DIV_LIN: begin
                // Skip both divides when no time has passed
                if (i_status.dt_zero) begin
                    o_cmd.op = OP_ZERO_VEL;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = OP_DIV_LIN;
                    n_state  = S_WAIT_LIN;
                end
            end
            S_WAIT_LIN: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_LIN_FIN;
                    n_state  = S_MUL_ANG;
                end
            end
            S_MUL_ANG: begin
                o_cmd.op = OP_MUL_ANG;
                n_state  = S_DIV_ANG;
            end
            S_DIV_ANG: begin
                o_cmd.op = OP_DIV_ANG;
                n_state  = S_WAIT_ANG;
            end
            S_WAIT_ANG: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_ANG_FIN;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/differential_drive_odometry_unit.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit
// Differential-drive wheel odometry: pose, velocities and yaw quaternion.
//
//   Channel  Direction  Handshake          Contents
//   input    in         i_valid / o_ready  wheel angles, noise, time stamp
//   output   out        o_valid / i_ready  pose, velocities, quat, dt_zero
//   config   in         APB psel/penable   wheel radius, wheel separation
//
// One word at a time. A word makes three passes through the shared
// bit-serial divider when time has passed and one when it has not; the
// other steps are sequenced around the shared multiplier.
// A finished word waits in the output register while the next is accepted;
// the final step stalls only if that register is still full.
// Reset is synchronous and clears pose, history and registers to defaults.
// ----------------------------------------------------------------------------
module differential_drive_odometry_unit import odo_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_left_position,
    input  logic signed [31:0] i_right_position,
    input  logic signed [15:0] i_left_noise,
    input  logic signed [15:0] i_right_noise,
    input  logic        [47:0] i_time_stamp,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_heading,
    output logic signed [31:0] o_linear_velocity,
    output logic signed [31:0] o_angular_velocity,
    output logic signed [15:0] o_quat_z,
    output logic signed [15:0] o_quat_w,
    output logic               o_dt_zero,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    logic [19:0] r_wheel_radius;
    logic [19:0] r_wheel_separation;
    t_cmd        cmd;
    t_status     status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_radius     <= 20'd2163;
            r_wheel_separation <= 20'd11141;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_RADIUS) begin
                r_wheel_radius <= pwdata[19:0];
            end else begin
                r_wheel_separation <= pwdata[19:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEPARATION) ? {12'b0, r_wheel_separation}
                                                 : {12'b0, r_wheel_radius};

    odo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    odo_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_wheel_radius     (r_wheel_radius),
        .i_wheel_separation (r_wheel_separation),
        .i_left_position    (i_left_position),
        .i_right_position   (i_right_position),
        .i_left_noise       (i_left_noise),
        .i_right_noise      (i_right_noise),
        .i_time_stamp       (i_time_stamp),
        .i_out_ready        (i_ready),
        .o_out_valid        (o_valid),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_heading          (o_heading),
        .o_linear_velocity  (o_linear_velocity),
        .o_angular_velocity (o_angular_velocity),
        .o_quat_z           (o_quat_z),
        .o_quat_w           (o_quat_w),
        .o_dt_zero          (o_dt_zero)
    );

endmodule

>>> sv/odo_chk.sv
// ----------------------------------------------------------------------------
// odo_chk
// Port-level checks of the odometry unit, bound to the top level.
// ----------------------------------------------------------------------------
module odo_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_pos_x,
    input logic signed [31:0] o_linear_velocity,
    input logic signed [31:0] o_angular_velocity,
    input logic               o_dt_zero
);

    // Drop the result word on reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word survives reset");

    // Go busy after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted a second word while busy");

    // No result appears the cycle after a word is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !$rose(o_valid))
        else $error("result word appeared too early");

    // Zero elapsed time forces zero velocities
    a_dt_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dt_zero) |-> (o_linear_velocity == 32'sd0 &&
                                    o_angular_velocity == 32'sd0))
        else $error("velocity nonzero with zero time delta");

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pos_x)))
        else $error("stalled result word changed");

endmodule

bind differential_drive_odometry_unit odo_chk u_odo_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_pos_x            (o_pos_x),
    .o_linear_velocity  (o_linear_velocity),
    .o_angular_velocity (o_angular_velocity),
    .o_dt_zero          (o_dt_zero)
);
